FILE: src/pds_pkg.sv
package pds_pkg;

    // Width of the signed input number and of the unsigned result.
    localparam int DATA_BITS = 32;
    localparam int SUM_BITS  = 34;

    // A positive input fits in the magnitude bits below the sign bit.
    localparam int MAG_BITS  = DATA_BITS - 1;

    // Trial divisors run up to the square root; one extra bit keeps i + 1 from wrapping.
    localparam int ROOT_BITS = DATA_BITS / 2 + 1;

    // Step counter of the serial divider.
    localparam int CNT_BITS  = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;

    // Stream widths rounded up to whole bytes.
    localparam int IN_TDATA_BITS  = ((DATA_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((SUM_BITS + 7) / 8) * 8;

    // Saturation limit of the sum.
    localparam logic [SUM_BITS-1:0] SUM_CAP = {SUM_BITS{1'b1}};

    // The running sum plus a divisor and its cofactor fits here before it is clamped.
    localparam int TOTAL_BITS = ((MAG_BITS > SUM_BITS) ? MAG_BITS : SUM_BITS) + 2;

    // Highest even power of two that fits in the magnitude bits.
    localparam int SQRT_SHIFT = 2 * ((MAG_BITS - 1) / 2);
    localparam logic [MAG_BITS-1:0] SQRT_TOP = {{(MAG_BITS-1){1'b0}}, 1'b1} << SQRT_SHIFT;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_TEST,
        ST_DIV,
        ST_DONE
    } state_t;

    // Status from the serial divider.
    typedef struct packed {
        logic done;   // one-cycle pulse when the quotient is complete
        logic exact;  // remainder is zero
    } div_stat_t;

endpackage

FILE: src/pds_div.sv
module pds_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pds_pkg::MAG_BITS-1:0]      dividend,
    input  logic [pds_pkg::ROOT_BITS-1:0]     divisor,
    output pds_pkg::div_stat_t                stat,
    output logic [pds_pkg::MAG_BITS-1:0]      quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [pds_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [pds_pkg::MAG_BITS-1:0]      dvd_reg, dvd_next;
    logic [pds_pkg::MAG_BITS-1:0]      rem_reg, rem_next;
    logic [pds_pkg::ROOT_BITS-1:0]     dsr_reg, dsr_next;

    logic [pds_pkg::MAG_BITS:0]        partial;
    logic [pds_pkg::MAG_BITS:0]        dsr_ext;
    logic [pds_pkg::MAG_BITS:0]        diff;
    logic                              fits;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb
    begin
        partial = {rem_reg, dvd_reg[pds_pkg::MAG_BITS-1]};
        dsr_ext = (pds_pkg::MAG_BITS + 1)'(dsr_reg);
        fits    = (partial >= dsr_ext);
        diff    = partial - dsr_ext;
    end

    // Quotient bits shift in at the bottom of the dividend register.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pds_pkg::CNT_BITS'(pds_pkg::MAG_BITS - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[pds_pkg::MAG_BITS-1:0] : partial[pds_pkg::MAG_BITS-1:0];
            dvd_next = {dvd_reg[pds_pkg::MAG_BITS-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done  = done_reg;
    assign stat.exact = (rem_reg == '0);
    assign quotient   = dvd_reg;

endmodule

FILE: src/proper_divisor_sum.sv
// An input below 2, or a negative one, goes straight to the result beat; otherwise the block takes
// the square root of n and then tries each divisor from 2 up to isqrt(n).
// Throughput: one item at a time; a new beat is taken once the result is registered and the
// sequencer is back in idle, which waits while the previous result is stalled. The bit-serial
// divider spends 31 steps on each trial divisor, and the square root takes 16 steps.
// Reset clears the sequencer and the output valid; no result is pending after reset.
module proper_divisor_sum
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pds_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // [31:0] number
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pds_pkg::OUT_TDATA_BITS-1:0]   m_tdata    // [33:0] divisor_sum, rest zero
);

    localparam int MB = pds_pkg::MAG_BITS;
    localparam int RB = pds_pkg::ROOT_BITS;
    localparam int SB = pds_pkg::SUM_BITS;
    localparam int TB = pds_pkg::TOTAL_BITS;

    pds_pkg::state_t          state_reg, state_next;
    logic [MB-1:0]            n_reg, n_next;
    logic [MB-1:0]            v_reg, v_next;
    logic [MB-1:0]            root_reg, root_next;
    logic [MB-1:0]            bit_reg, bit_next;
    logic [RB-1:0]            i_reg, i_next;
    logic [SB-1:0]            sum_reg, sum_next;
    logic [SB-1:0]            out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic [pds_pkg::DATA_BITS-1:0] number;
    logic [MB:0]              root_try;
    logic [MB:0]              i_ext;
    logic [MB-1:0]            i_mag;
    logic [TB-1:0]            total;
    logic [MB-1:0]            cofactor;
    logic                     div_start;
    pds_pkg::div_stat_t       div_stat;

    // Shared serial divider for n / i.
    pds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (i_reg),
        .stat     (div_stat),
        .quotient (cofactor)
    );

    // Helpers for the root step and the sum update.
    always_comb
    begin
        number   = s_tdata[pds_pkg::DATA_BITS-1:0];
        root_try = (MB + 1)'(root_reg) + (MB + 1)'(bit_reg);
        i_ext    = (MB + 1)'(i_reg);
        i_mag    = MB'(i_reg);
        total    = TB'(sum_reg) + TB'(i_reg)
                 + ((cofactor != i_mag) ? TB'(cofactor) : '0);
    end

    // Sequencer: square root, then one trial division per candidate divisor.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        v_next         = v_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        i_next         = i_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        s_tready       = (state_reg == pds_pkg::ST_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next    = number[MB-1:0];
                    v_next    = number[MB-1:0];
                    root_next = '0;
                    bit_next  = pds_pkg::SQRT_TOP;
                    if (!number[pds_pkg::DATA_BITS-1] && (number[MB-1:0] > MB'(1)))
                    begin
                        sum_next   = SB'(1);
                        state_next = pds_pkg::ST_ROOT;
                    end
                    else
                    begin
                        sum_next   = '0;
                        state_next = pds_pkg::ST_DONE;
                    end
                end
            end
            pds_pkg::ST_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    i_next     = RB'(2);
                    state_next = pds_pkg::ST_TEST;
                end
                else
                begin
                    if ((MB + 1)'(v_reg) >= root_try)
                    begin
                        v_next    = v_reg - root_try[MB-1:0];
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            pds_pkg::ST_TEST:
            begin
                if (i_ext > (MB + 1)'(root_reg))
                begin
                    state_next = pds_pkg::ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = pds_pkg::ST_DIV;
                end
            end
            pds_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.exact)
                    begin
                        sum_next = (total >= TB'(pds_pkg::SUM_CAP))
                                 ? pds_pkg::SUM_CAP : total[SB-1:0];
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = pds_pkg::ST_TEST;
                end
            end
            pds_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = sum_reg;
                    out_valid_next = 1'b1;
                    state_next     = pds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pds_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pds_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        i_reg    <= i_next;
        sum_reg  <= sum_next;
        out_reg  <= out_next;
    end

    // Output beat, zero-padded to whole bytes.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pds_pkg::OUT_TDATA_BITS'(out_reg);

endmodule

FILE: tb/divisor_sum_monitor.sv
`timescale 1ns / 1ps

module divisor_sum_monitor
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [pds_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [31:0] number
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [pds_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [33:0] divisor_sum, rest zero
    output int                                 mismatch_count,
    output int                                 sums_outstanding
);

    // One accepted number together with the sum it must produce.
    typedef struct packed {
        logic [pds_pkg::DATA_BITS-1:0] number;
        logic [pds_pkg::SUM_BITS-1:0]  sum;
    } sum_entry_t;

    sum_entry_t expected_sums[$];

    // Sum of the proper divisors by trial division up to the exact integer square root.
    function automatic logic [pds_pkg::SUM_BITS-1:0] aliquot_sum(
        input logic [pds_pkg::DATA_BITS-1:0] raw);
        longint unsigned n;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned weight;
        longint unsigned acc;
        longint unsigned cofactor;
        longint unsigned i;
        n = {{(64 - pds_pkg::DATA_BITS){1'b0}}, raw};
        if (raw[pds_pkg::DATA_BITS-1] || n < 2)
        begin
            return '0;
        end

        // Digit-by-digit square root, two bits per step.
        rem = n;
        root = 0;
        weight = 64'd1 << 62;
        while (weight > rem)
        begin
            weight = weight >> 2;
        end
        while (weight != 0)
        begin
            if (rem >= root + weight)
            begin
                rem = rem - (root + weight);
                root = (root >> 1) + weight;
            end
            else
            begin
                root = root >> 1;
            end
            weight = weight >> 2;
        end

        // The divisor 1 is always there; a square root is counted once.
        acc = 1;
        for (i = 2; i <= root; i++)
        begin
            if (n % i == 0)
            begin
                cofactor = n / i;
                acc = acc + i;
                if (cofactor != i)
                begin
                    acc = acc + cofactor;
                end
                if (acc > pds_pkg::SUM_CAP)
                begin
                    acc = pds_pkg::SUM_CAP;
                end
            end
        end
        return acc[pds_pkg::SUM_BITS-1:0];
    endfunction

    // Record each accepted number and compare each accepted result with the oldest one.
    always @(posedge clk)
    begin : watch_beats
        sum_entry_t head;
        sum_entry_t entry;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                entry.number = s_tdata[pds_pkg::DATA_BITS-1:0];
                entry.sum = aliquot_sum(s_tdata[pds_pkg::DATA_BITS-1:0]);
                expected_sums = {expected_sums, entry};
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected result beat, divisor_sum %0d with no number pending",
                             $time, m_tdata[pds_pkg::SUM_BITS-1:0]);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    head = expected_sums.pop_front();
                    if (m_tdata[pds_pkg::SUM_BITS-1:0] !== head.sum)
                    begin
                        $display("%0t: divisor_sum mismatch for number %0d: expected %0d, got %0d",
                                 $time, $signed(head.number), head.sum,
                                 m_tdata[pds_pkg::SUM_BITS-1:0]);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            sums_outstanding <= expected_sums.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_NUMBERS = 78;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [pds_pkg::IN_TDATA_BITS-1:0]  s_tdata;   // [31:0] number
    logic                               m_tvalid;
    logic                               m_tready;
    logic [pds_pkg::OUT_TDATA_BITS-1:0] m_tdata;   // [33:0] divisor_sum, rest zero

    int mismatch_count;
    int sums_outstanding;
    int cycle_count = 0;
    bit tx_quiet;
    bit rx_quiet;

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    proper_divisor_sum u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    divisor_sum_monitor u_sum_monitor
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .sums_outstanding (sums_outstanding)
    );

    // Hard stop for a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one number, after an optional gap, and hold it until the beat is taken.
    task automatic send_number(input logic [pds_pkg::DATA_BITS-1:0] value);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pds_pkg::IN_TDATA_BITS'(value);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Result side: either ready all along, or hold off for a random stall after a result shows up.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(negedge clk);
        while (!rst_n)
        begin
            @(negedge clk);
        end
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(0, 4);
            if (stall == 0)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b0;
                while (!m_tvalid)
                begin
                    @(negedge clk);
                end
                repeat (stall) @(negedge clk);
                m_tready <= 1'b1;
            end
            @(posedge clk);
            while (!(m_tvalid && m_tready))
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [pds_pkg::DATA_BITS-1:0] numbers[$];
        logic [pds_pkg::DATA_BITS-1:0] pick;
        int unsigned root;
        int kind;
        s_tvalid = 1'b0;
        s_tdata = '0;
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: sign extremes, zero and one, small perfect numbers, squares, primes,
        // powers of two and the largest positive value, which is prime.
        numbers = '{32'h8000_0000, 32'hFFFF_FFFF, -32'sd12345678, 32'd0, 32'd1, 32'd2, 32'd3,
                    32'd4, 32'd6, 32'd12, 32'd25, 32'd28, 32'd36, 32'd97, 32'd120, 32'd496,
                    32'd1024, 32'd65535, 32'd65536, 32'd720720, 32'd8128, 32'h7FFF_FFFF};

        // Random: mostly small values so that trial division stays short.
        repeat (RANDOM_NUMBERS)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 4)
            begin
                pick = $urandom() | 32'h8000_0000;
            end
            else if (kind == 4)
            begin
                pick = $urandom_range(0, 2);
            end
            else if (kind < 12)
            begin
                pick = $urandom_range(2, 1023);
            end
            else if (kind < 17)
            begin
                pick = $urandom_range(1024, 65535);
            end
            else if (kind < 19)
            begin
                pick = $urandom_range(65536, 1 << 20);
            end
            else
            begin
                root = $urandom_range(2, 1000);
                pick = root * root;
            end
            numbers = {numbers, pick};
        end

        // Flow-control phases change every eight beats.
        foreach (numbers[idx])
        begin
            if (idx % 8 == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            send_number(numbers[idx]);
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then watch for stray beats.
        while (sums_outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && sums_outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
